[rtl/assert_macros.svh]
// Assertion macros shared by the tessellator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is high.
`define BCT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that also holds during reset.
`define BCT_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/bct_pkg.sv]
// Shared types, constants and the per-point schedule of the tessellator.
package bct_pkg;

   localparam int COORD_WIDTH   = 32;
   localparam int WFRAC         = 63 - COORD_WIDTH;       // weight fraction bits
   localparam int EXACT_FRAC    = 48;                     // exact Bernstein fraction bits
   localparam int W_SHIFT       = EXACT_FRAC - WFRAC;     // exact -> weight
   localparam int SEG_WIDTH     = 6;
   localparam int T_WIDTH       = 16;                     // t in Q0.16
   localparam int U_WIDTH       = T_WIDTH + 1;            // u in Q1.16
   localparam int DIV_STEPS     = T_WIDTH + 1;            // quotient bits of 2^16 / N
   localparam int DIV_CNT_WIDTH = $clog2(DIV_STEPS + 1);
   localparam int STEP_WIDTH    = 5;
   localparam int MUL_WIDTH     = COORD_WIDTH + 1;
   localparam int PROD_WIDTH    = 2 * MUL_WIDTH;
   localparam int ACC_WIDTH     = 2 * COORD_WIDTH;
   localparam int WSUM_WIDTH    = COORD_WIDTH + 2;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic [COORD_WIDTH-1:0]        weight_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_CALC,
      ST_EMIT,
      ST_LAST
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_UU,
      OP_UT,
      OP_TT,
      OP_UUT,
      OP_UTT,
      OP_TTT,
      OP_W0,
      OP_X0,
      OP_X1,
      OP_X2,
      OP_X3,
      OP_Y0,
      OP_Y1,
      OP_Y2,
      OP_Y3,
      OP_ROUND,
      OP_END
   } op_type;

   typedef struct packed {
      op_type op;
      logic   capture;
      logic   load_out;
      logic   out_last;
      logic   advance;
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
      logic seg_zero;
      logic pt_last;
      logic out_free;
      logic cubic;
   } dp_stat_type;

   // At most one multiplier issue per step; a result is consumed the cycle after.
   function automatic op_type step_op(input logic cubic,
                                      input logic [STEP_WIDTH-1:0] step);
      op_type op;
      op = OP_END;
      if (cubic) begin
         case (step)
            5'd0:    op = OP_UU;
            5'd1:    op = OP_UT;
            5'd2:    op = OP_TT;
            5'd3:    op = OP_UUT;
            5'd4:    op = OP_UTT;
            5'd5:    op = OP_TTT;
            5'd6:    op = OP_W0;
            5'd7:    op = OP_NONE;   // w0 lands
            5'd8:    op = OP_X0;
            5'd9:    op = OP_X1;
            5'd10:   op = OP_X2;
            5'd11:   op = OP_X3;
            5'd12:   op = OP_Y0;
            5'd13:   op = OP_Y1;
            5'd14:   op = OP_Y2;
            5'd15:   op = OP_Y3;
            5'd16:   op = OP_ROUND;
            default: op = OP_END;
         endcase
      end else begin
         case (step)
            5'd0:    op = OP_UT;
            5'd1:    op = OP_TT;
            5'd2:    op = OP_W0;
            5'd3:    op = OP_NONE;   // w0 lands
            5'd4:    op = OP_X0;
            5'd5:    op = OP_X1;
            5'd6:    op = OP_X2;
            5'd7:    op = OP_Y0;
            5'd8:    op = OP_Y1;
            5'd9:    op = OP_Y2;
            5'd10:   op = OP_ROUND;
            default: op = OP_END;
         endcase
      end
      return op;
   endfunction

endpackage

[rtl/bct_ctrl.sv]
// Sequencer of the tessellator: curve phases and the per-point step schedule.
`include "assert_macros.svh"

module bct_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  bct_pkg::dp_stat_type stat,
   output bct_pkg::dp_cmd_type  cmd
);
   import bct_pkg::*;

   state_type               state_ff, state_in;
   logic [STEP_WIDTH-1:0]   step_ff, step_in;
   op_type                  op_cur;

   assign op_cur = step_op(stat.cubic, step_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      step_in  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (stat.div_done) state_in = stat.seg_zero ? ST_LAST : ST_CALC;
         end
         ST_CALC: begin
            if (op_cur == OP_END) begin
               state_in = ST_EMIT;
            end else begin
               step_in = step_ff + STEP_WIDTH'(1);
            end
         end
         ST_EMIT: begin
            if (stat.out_free) state_in = stat.pt_last ? ST_LAST : ST_CALC;
         end
         ST_LAST: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready    = 1'b0;
      cmd.op       = OP_NONE;
      cmd.capture  = 1'b0;
      cmd.load_out = 1'b0;
      cmd.out_last = 1'b0;
      cmd.advance  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_DIV: ;
         ST_CALC: begin
            if (op_cur != OP_END) cmd.op = op_cur;
         end
         ST_EMIT: begin
            cmd.load_out = stat.out_free;
            cmd.advance  = stat.out_free;
         end
         ST_LAST: begin
            cmd.load_out = stat.out_free;
            cmd.out_last = 1'b1;
         end
         default: ;
      endcase
   end

   `BCT_ASSERT(a_emit_step_zero, clock, reset, (state_ff == ST_EMIT) |-> (step_ff == '0), "point emitted with schedule not restarted")
   `BCT_ASSERT(a_calc_from_emit, clock, reset, ((state_ff == ST_EMIT) && stat.out_free && !stat.pt_last) |=> ((state_ff == ST_CALC) && (step_ff == '0)), "next point did not restart schedule")

endmodule

[rtl/bct_dp.sv]
// Datapath: operand store, 2^16/N divider, t = i/N stepping, shared multiplier, accumulators, output word.
`include "assert_macros.svh"

module bct_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  bct_pkg::dp_cmd_type                    cmd,
   output bct_pkg::dp_stat_type                   stat,
   input  logic                                   req_opcode,
   input  logic signed [bct_pkg::COORD_WIDTH-1:0] req_start_x,
   input  logic signed [bct_pkg::COORD_WIDTH-1:0] req_start_y,
   input  logic signed [bct_pkg::COORD_WIDTH-1:0] req_ctrl1_x,
   input  logic signed [bct_pkg::COORD_WIDTH-1:0] req_ctrl1_y,
   input  logic signed [bct_pkg::COORD_WIDTH-1:0] req_ctrl2_x,
   input  logic signed [bct_pkg::COORD_WIDTH-1:0] req_ctrl2_y,
   input  logic signed [bct_pkg::COORD_WIDTH-1:0] req_end_x,
   input  logic signed [bct_pkg::COORD_WIDTH-1:0] req_end_y,
   input  logic [bct_pkg::SEG_WIDTH-1:0]          req_segment_count,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [bct_pkg::COORD_WIDTH-1:0] rsp_point_x,
   output logic signed [bct_pkg::COORD_WIDTH-1:0] rsp_point_y,
   output logic                                   rsp_last_point
);
   import bct_pkg::*;

   localparam int QW        = ACC_WIDTH - WFRAC;
   localparam int DIVW      = U_WIDTH + SEG_WIDTH;
   localparam logic [U_WIDTH-1:0]    T_ONE  = U_WIDTH'(1) << T_WIDTH;
   localparam logic [WSUM_WIDTH-1:0] W_ONE  = WSUM_WIDTH'(1) << WFRAC;
   localparam logic [DIVW-1:0]       DIV_ONE = DIVW'(1) << T_WIDTH;
   localparam logic signed [ACC_WIDTH-1:0] HALF_LSB = ACC_WIDTH'(1) << (WFRAC - 1);
   localparam coord_type COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   // curve operands
   coord_type                p_x_ff [4];
   coord_type                p_y_ff [4];
   coord_type                end_x_ff, end_y_ff;
   logic                     cubic_ff;
   logic [SEG_WIDTH-1:0]     n_ff;

   // 2^16 / N, one quotient bit a cycle
   logic [DIV_CNT_WIDTH-1:0] div_cnt_ff;
   logic [U_WIDTH-1:0]       div_q_ff;
   logic [SEG_WIDTH-1:0]     div_rem_ff;
   logic [SEG_WIDTH:0]       div_trial;
   logic                     div_ge;
   logic                     div_busy;

   // t = floor(i * 2^16 / N) stepped exactly by quotient and remainder
   logic [U_WIDTH-1:0]       t_ff;
   logic [SEG_WIDTH-1:0]     r_ff;
   logic [SEG_WIDTH-1:0]     idx_ff;
   logic [SEG_WIDTH:0]       r_sum;
   logic                     r_wrap;
   logic [U_WIDTH-1:0]       u_val;

   // multiplier and weights
   logic signed [MUL_WIDTH-1:0]  mul_a, mul_b;
   logic signed [PROD_WIDTH-1:0] prod_ff;
   op_type                       op_ff;
   weight_type                   uu_ff, ut_ff, tt_ff;
   weight_type                   w_ff [4];
   logic [WSUM_WIDTH-1:0]        w_rest;
   logic [W_SHIFT+COORD_WIDTH:0] prod_x3;

   logic signed [ACC_WIDTH-1:0]  acc_x_ff, acc_y_ff;
   coord_type                    res_x_ff, res_y_ff;

   // output word
   logic                         rsp_valid_ff;
   coord_type                    rsp_x_ff, rsp_y_ff;
   logic                         rsp_last_ff;
   logic                         out_free;

   function automatic coord_type round_sat(input logic signed [ACC_WIDTH-1:0] a);
      logic signed [ACC_WIDTH-1:0] s;
      logic signed [QW-1:0]        q;
      coord_type                   r;
      s = a + HALF_LSB;
      q = s[ACC_WIDTH-1:WFRAC];               // floor after half-lsb bias
      if (q[QW-1:COORD_WIDTH-1] != {(QW-COORD_WIDTH+1){q[QW-1]}}) begin
         r = q[QW-1] ? COORD_MIN : COORD_MAX;
      end else begin
         r = q[COORD_WIDTH-1:0];
      end
      return r;
   endfunction

   // ---------------- capture ----------------
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cubic_ff  <= req_opcode;
         n_ff      <= req_segment_count;   // 6-bit N, at most 63
         p_x_ff[0] <= req_start_x;
         p_y_ff[0] <= req_start_y;
         p_x_ff[1] <= req_ctrl1_x;
         p_y_ff[1] <= req_ctrl1_y;
         p_x_ff[2] <= req_opcode ? req_ctrl2_x : req_end_x;
         p_y_ff[2] <= req_opcode ? req_ctrl2_y : req_end_y;
         p_x_ff[3] <= req_opcode ? req_end_x : '0;
         p_y_ff[3] <= req_opcode ? req_end_y : '0;
         end_x_ff  <= req_end_x;
         end_y_ff  <= req_end_y;
      end
   end

   // ---------------- divider ----------------
   assign div_busy  = (div_cnt_ff != DIV_CNT_WIDTH'(DIV_STEPS));
   assign div_trial = {div_rem_ff, (div_cnt_ff == '0)};   // dividend is a lone top bit
   assign div_ge    = (div_trial >= {1'b0, n_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (cmd.capture) begin
         div_cnt_ff <= '0;
      end else if (div_busy) begin
         div_cnt_ff <= div_cnt_ff + DIV_CNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         div_q_ff   <= '0;
         div_rem_ff <= '0;
      end else if (div_busy) begin
         div_q_ff   <= {div_q_ff[U_WIDTH-2:0], div_ge};
         div_rem_ff <= div_ge ? SEG_WIDTH'(div_trial - {1'b0, n_ff})
                              : div_trial[SEG_WIDTH-1:0];
      end
   end

   // ---------------- t stepping ----------------
   assign r_sum  = {1'b0, r_ff} + {1'b0, div_rem_ff};
   assign r_wrap = (r_sum >= {1'b0, n_ff});
   assign u_val  = T_ONE - t_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         t_ff   <= '0;
         r_ff   <= '0;
         idx_ff <= '0;
      end else if (cmd.advance) begin
         t_ff   <= t_ff + div_q_ff + U_WIDTH'(r_wrap);
         r_ff   <= r_wrap ? SEG_WIDTH'(r_sum - {1'b0, n_ff}) : r_sum[SEG_WIDTH-1:0];
         idx_ff <= idx_ff + SEG_WIDTH'(1);
      end
   end

   // ---------------- multiplier issue ----------------
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_UU:  begin mul_a = MUL_WIDTH'(u_val);  mul_b = MUL_WIDTH'(u_val); end
         OP_UT:  begin mul_a = MUL_WIDTH'(u_val);  mul_b = MUL_WIDTH'(t_ff[T_WIDTH-1:0]); end
         OP_TT:  begin mul_a = MUL_WIDTH'(t_ff[T_WIDTH-1:0]);
                       mul_b = MUL_WIDTH'(t_ff[T_WIDTH-1:0]); end
         OP_UUT: begin mul_a = MUL_WIDTH'(uu_ff);  mul_b = MUL_WIDTH'(t_ff[T_WIDTH-1:0]); end
         OP_UTT: begin mul_a = MUL_WIDTH'(ut_ff);  mul_b = MUL_WIDTH'(t_ff[T_WIDTH-1:0]); end
         OP_TTT: begin mul_a = MUL_WIDTH'(tt_ff);  mul_b = MUL_WIDTH'(t_ff[T_WIDTH-1:0]); end
         OP_X0:  begin mul_a = MUL_WIDTH'(w_ff[0]); mul_b = MUL_WIDTH'(p_x_ff[0]); end
         OP_X1:  begin mul_a = MUL_WIDTH'(w_ff[1]); mul_b = MUL_WIDTH'(p_x_ff[1]); end
         OP_X2:  begin mul_a = MUL_WIDTH'(w_ff[2]); mul_b = MUL_WIDTH'(p_x_ff[2]); end
         OP_X3:  begin mul_a = MUL_WIDTH'(w_ff[3]); mul_b = MUL_WIDTH'(p_x_ff[3]); end
         OP_Y0:  begin mul_a = MUL_WIDTH'(w_ff[0]); mul_b = MUL_WIDTH'(p_y_ff[0]); end
         OP_Y1:  begin mul_a = MUL_WIDTH'(w_ff[1]); mul_b = MUL_WIDTH'(p_y_ff[1]); end
         OP_Y2:  begin mul_a = MUL_WIDTH'(w_ff[2]); mul_b = MUL_WIDTH'(p_y_ff[2]); end
         OP_Y3:  begin mul_a = MUL_WIDTH'(w_ff[3]); mul_b = MUL_WIDTH'(p_y_ff[3]); end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff <= OP_NONE;
      end else begin
         op_ff <= cmd.op;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // ---------------- consume ----------------
   // 3x of an exact cubic term, then down to the weight scale
   assign prod_x3 = prod_ff[W_SHIFT+COORD_WIDTH:0] + {prod_ff[W_SHIFT+COORD_WIDTH-1:0], 1'b0};
   assign w_rest  = WSUM_WIDTH'(w_ff[1]) + WSUM_WIDTH'(w_ff[2]) + WSUM_WIDTH'(w_ff[3]);

   always_ff @(posedge clock) begin
      case (op_ff)
         OP_UU: uu_ff <= prod_ff[COORD_WIDTH-1:0];   // wraps at t = 0, only times t then
         OP_UT: begin
            ut_ff <= prod_ff[COORD_WIDTH-1:0];
            if (!cubic_ff) w_ff[1] <= prod_ff[COORD_WIDTH-1:0];
         end
         OP_TT: begin
            tt_ff <= prod_ff[COORD_WIDTH-1:0];
            if (!cubic_ff) begin
               w_ff[2] <= prod_ff[COORD_WIDTH:1];
               w_ff[3] <= '0;
            end
         end
         OP_UUT: w_ff[1] <= prod_x3[W_SHIFT +: COORD_WIDTH];
         OP_UTT: w_ff[2] <= prod_x3[W_SHIFT +: COORD_WIDTH];
         OP_TTT: w_ff[3] <= prod_ff[W_SHIFT +: COORD_WIDTH];
         OP_W0:  w_ff[0] <= COORD_WIDTH'(W_ONE - w_rest);
         OP_X0:  acc_x_ff <= prod_ff[ACC_WIDTH-1:0];
         OP_X1, OP_X2, OP_X3: acc_x_ff <= acc_x_ff + prod_ff[ACC_WIDTH-1:0];
         OP_Y0:  acc_y_ff <= prod_ff[ACC_WIDTH-1:0];
         OP_Y1, OP_Y2, OP_Y3: acc_y_ff <= acc_y_ff + prod_ff[ACC_WIDTH-1:0];
         OP_ROUND: begin
            res_x_ff <= round_sat(acc_x_ff);
            res_y_ff <= round_sat(acc_y_ff);
         end
         default: ;
      endcase
   end

   // ---------------- output word ----------------
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_x_ff    <= cmd.out_last ? end_x_ff : res_x_ff;
         rsp_y_ff    <= cmd.out_last ? end_y_ff : res_y_ff;
         rsp_last_ff <= cmd.out_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_point_x    = rsp_x_ff;
   assign rsp_point_y    = rsp_y_ff;
   assign rsp_last_point = rsp_last_ff;

   assign stat.div_done = !div_busy;
   assign stat.seg_zero = (n_ff == '0);
   assign stat.pt_last  = (idx_ff == n_ff - SEG_WIDTH'(1));
   assign stat.out_free = out_free;
   assign stat.cubic    = cubic_ff;

   `BCT_ASSERT(a_weights_unity, clock, reset, (op_ff == OP_W0) |=> ((WSUM_WIDTH'(w_ff[0]) + w_rest) == W_ONE), "Bernstein weights do not sum to one")
   `BCT_ASSERT(a_div_exact, clock, reset, ($fell(div_busy) && (n_ff != '0)) |-> (((DIVW'(div_q_ff) * DIVW'(n_ff)) + DIVW'(div_rem_ff)) == DIV_ONE), "step quotient and remainder inconsistent")

endmodule

[rtl/bezier_curve_tessellator.sv]
// Top level of the quadratic/cubic Bezier tessellator.
//
//  channel  dir  handshake            word
//  req_     in   req_valid/req_ready  one curve: opcode, 4 points, segment count N
//  rsp_     out  rsp_valid/rsp_ready  one point: x, y, last_point
//
//  One curve at a time: accept, then the divide (17 shift-subtract steps for 2^16/N),
//  then per point the cubic or quadratic step schedule on the one shared 33x33
//  multiplier plus an emit, then the end point (alone when N is zero).
//  Reset is synchronous, clears the sequencer, divider count, issued op and output valid; no sweep.
//  A stalled rsp_ holds the sequencer in emit; the next point is computed while
//  the previous word waits in the output register.
module bezier_curve_tessellator (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_opcode,
   input  logic signed [bct_pkg::COORD_WIDTH-1:0] req_start_x,
   input  logic signed [bct_pkg::COORD_WIDTH-1:0] req_start_y,
   input  logic signed [bct_pkg::COORD_WIDTH-1:0] req_ctrl1_x,
   input  logic signed [bct_pkg::COORD_WIDTH-1:0] req_ctrl1_y,
   input  logic signed [bct_pkg::COORD_WIDTH-1:0] req_ctrl2_x,
   input  logic signed [bct_pkg::COORD_WIDTH-1:0] req_ctrl2_y,
   input  logic signed [bct_pkg::COORD_WIDTH-1:0] req_end_x,
   input  logic signed [bct_pkg::COORD_WIDTH-1:0] req_end_y,
   input  logic [bct_pkg::SEG_WIDTH-1:0]          req_segment_count,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [bct_pkg::COORD_WIDTH-1:0] rsp_point_x,
   output logic signed [bct_pkg::COORD_WIDTH-1:0] rsp_point_y,
   output logic                                   rsp_last_point
);
   import bct_pkg::*;

   // command and status between sequencer and datapath
   dp_cmd_type  cmd;
   dp_stat_type stat;

   // sequencer: idle / divide / per-point steps / emit / end point
   bct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath: operands, t stepping, multiplier, accumulators, output word
   bct_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_opcode        (req_opcode),
      .req_start_x       (req_start_x),
      .req_start_y       (req_start_y),
      .req_ctrl1_x       (req_ctrl1_x),
      .req_ctrl1_y       (req_ctrl1_y),
      .req_ctrl2_x       (req_ctrl2_x),
      .req_ctrl2_y       (req_ctrl2_y),
      .req_end_x         (req_end_x),
      .req_end_y         (req_end_y),
      .req_segment_count (req_segment_count),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_point_x       (rsp_point_x),
      .rsp_point_y       (rsp_point_y),
      .rsp_last_point    (rsp_last_point)
   );

endmodule
